>>> src/biquad_pkg.sv
// Shared constants for the multichannel biquad filter: field widths,
// parameter defaults and coefficient register indexes.
// No dependencies.
package biquad_pkg;

   localparam int CHAN_BITS    = 3;
   localparam int COEF_BITS    = 32;
   localparam int CSR_IDX_BITS = 3;

   localparam int DEF_CHANNELS       = 8;
   localparam int DEF_SAMPLE_BITS    = 24;
   localparam int DEF_COEF_FRAC_BITS = 28;

   localparam logic [CSR_IDX_BITS-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_A2 = 3'd4;

endpackage

>>> src/biquad_req_if.sv
// Input sample channel: valid/ready plus channel, sample and frame marker.
// Depends on biquad_pkg.
interface biquad_req_if #(parameter int SAMPLE_BITS = biquad_pkg::DEF_SAMPLE_BITS);
   import biquad_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CHAN_BITS-1:0]          channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          frame_end;

   modport source (output valid, channel, sample_in, frame_end, input ready);
   modport sink   (input valid, channel, sample_in, frame_end, output ready);
endinterface

>>> src/biquad_rsp_if.sv
// Result channel: valid/ready plus channel, filtered sample and flags.
// Depends on biquad_pkg.
interface biquad_rsp_if #(parameter int SAMPLE_BITS = biquad_pkg::DEF_SAMPLE_BITS);
   import biquad_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CHAN_BITS-1:0]          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          frame_end_out;
   logic                          saturated;

   modport source (output valid, channel_out, sample_out, frame_end_out, saturated,
                   input ready);
   modport sink   (input valid, channel_out, sample_out, frame_end_out, saturated,
                   output ready);
endinterface

>>> src/biquad_csr_if.sv
// Coefficient write channel: valid/ready, register index and data.
// Depends on biquad_pkg.
interface biquad_csr_if;
   import biquad_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [COEF_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/multichannel_biquad_iir.sv
// Multichannel direct form I biquad. Stages s1, s2, s3 and out lie between a
// taken input word and its result. Throughput: one word per cycle while channels
// differ and the receiver does not stall; a word for the same channel waits for
// the one ahead of it to write back its history (history RAM loop). Reset:
// coefficients go to pass-through (b0 = 1.0), history reads as zero via
// per-channel valid bits; no clearing pass, words are taken right after reset.
module multichannel_biquad_iir #(
   parameter int CHANNELS       = biquad_pkg::DEF_CHANNELS,
   parameter int SAMPLE_BITS    = biquad_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = biquad_pkg::DEF_COEF_FRAC_BITS
) (
   input logic          clock,
   input logic          reset,
   biquad_csr_if.sink   csr_chan,
   biquad_req_if.sink   req_chan,
   biquad_rsp_if.source rsp_chan
);
   import biquad_pkg::*;

   localparam int MAX_CH    = 1 << CHAN_BITS;
   localparam int DEPTH     = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HIST_BITS = 4 * SAMPLE_BITS;
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam int TOP_LSB   = COEF_FRAC_BITS + SAMPLE_BITS - 1;

   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [COEF_BITS-1:0] ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // coefficients
   logic signed [COEF_BITS-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_B0:  b0_ff <= csr_chan.data;
            CSR_B1:  b1_ff <= csr_chan.data;
            CSR_B2:  b2_ff <= csr_chan.data;
            CSR_A1:  a1_ff <= csr_chan.data;
            CSR_A2:  a2_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                          s1_ok_ff, s2_ok_ff, s3_ok_ff;
   logic [CHAN_BITS-1:0]          s1_chan_ff, s2_chan_ff, s3_chan_ff;
   logic                          s1_fe_ff, s2_fe_ff, s3_fe_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff, s2_x_ff, s3_x_ff;
   logic signed [SAMPLE_BITS-1:0] s2_x1_ff, s3_x1_ff, s2_y1_ff, s3_y1_ff;

   logic advance, hazard, accept, req_ok;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign req_ok  = 32'(req_chan.channel) < 32'(CHANNELS);

   // interlock: same channel still in flight has not written its history back
   assign hazard = (s1_valid_ff && s1_ok_ff && s1_chan_ff == req_chan.channel) ||
                   (s2_valid_ff && s2_ok_ff && s2_chan_ff == req_chan.channel) ||
                   (s3_valid_ff && s3_ok_ff && s3_chan_ff == req_chan.channel);

   assign req_chan.ready = advance && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;

   // history RAM: {x1, x2, y1, y2} per channel
   logic [HIST_BITS-1:0] hist_mem [DEPTH];
   logic [DEPTH-1:0]     live_ff;
   logic [HIST_BITS-1:0] rd_ff;
   logic                 rd_live_ff;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr, rd_addr;
   logic [HIST_BITS-1:0] wr_data;

   assign rd_addr = IDX_BITS'(req_chan.channel);

   always_ff @(posedge clock) begin
      if (accept && req_ok) begin
         rd_ff <= hist_mem[rd_addr];
      end
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         if (accept) begin
            rd_live_ff <= req_ok && live_ff[rd_addr];
         end
         if (wr_en) begin
            live_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // stage 1: five products
   logic [HIST_BITS-1:0]          hist;
   logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;
   logic signed [PROD_BITS-1:0]   p0, p1, p2, p3, p4;

   assign hist = rd_live_ff ? rd_ff : '0;
   assign x1   = hist[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
   assign x2   = hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
   assign y1   = hist[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign y2   = hist[SAMPLE_BITS-1:0];

   assign p0 = PROD_BITS'(b0_ff) * PROD_BITS'(s1_x_ff);
   assign p1 = PROD_BITS'(b1_ff) * PROD_BITS'(x1);
   assign p2 = PROD_BITS'(b2_ff) * PROD_BITS'(x2);
   assign p3 = PROD_BITS'(a1_ff) * PROD_BITS'(y1);
   assign p4 = PROD_BITS'(a2_ff) * PROD_BITS'(y2);

   logic signed [PROD_BITS-1:0] s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff;
   logic signed [ACC_BITS-1:0]  s3_sa_ff, s3_sb_ff;

   // stage 3: final add, round, saturate
   logic signed [ACC_BITS-1:0]    acc;
   logic [ACC_BITS-TOP_LSB-1:0]   upper;
   logic                          in_range;
   logic signed [SAMPLE_BITS-1:0] y;
   logic                          sat;

   assign acc      = s3_sa_ff + s3_sb_ff;
   assign upper    = acc[ACC_BITS-1:TOP_LSB];
   assign in_range = (&upper) || !(|upper);

   always_comb begin
      if (!s3_ok_ff) begin
         y   = '0;
         sat = 1'b0;
      end else if (in_range) begin
         y   = acc[TOP_LSB:COEF_FRAC_BITS];
         sat = 1'b0;
      end else begin
         y   = acc[ACC_BITS-1] ? MINV : MAXV;
         sat = 1'b1;
      end
   end

   assign wr_en   = advance && s3_valid_ff && s3_ok_ff;
   assign wr_addr = IDX_BITS'(s3_chan_ff);
   assign wr_data = {s3_x_ff, s3_x1_ff, y, s3_y1_ff};

   logic [CHAN_BITS-1:0]          out_chan_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_fe_ff, out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (accept) begin
            s1_ok_ff   <= req_ok;
            s1_chan_ff <= req_chan.channel;
            s1_x_ff    <= req_chan.sample_in;
            s1_fe_ff   <= req_chan.frame_end;
         end
         s2_ok_ff   <= s1_ok_ff;
         s2_chan_ff <= s1_chan_ff;
         s2_x_ff    <= s1_x_ff;
         s2_fe_ff   <= s1_fe_ff;
         s2_x1_ff   <= x1;
         s2_y1_ff   <= y1;
         s2_p0_ff   <= p0;
         s2_p1_ff   <= p1;
         s2_p2_ff   <= p2;
         s2_p3_ff   <= p3;
         s2_p4_ff   <= p4;

         s3_ok_ff   <= s2_ok_ff;
         s3_chan_ff <= s2_chan_ff;
         s3_x_ff    <= s2_x_ff;
         s3_fe_ff   <= s2_fe_ff;
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         // rounding half folded into the feedforward partial sum
         s3_sa_ff   <= ACC_BITS'(s2_p0_ff) + ACC_BITS'(s2_p1_ff) + HALF;
         s3_sb_ff   <= ACC_BITS'(s2_p2_ff) - ACC_BITS'(s2_p3_ff) - ACC_BITS'(s2_p4_ff);

         if (s3_valid_ff) begin
            out_chan_ff   <= s3_chan_ff;
            out_sample_ff <= y;
            out_fe_ff     <= s3_fe_ff;
            out_sat_ff    <= sat;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.channel_out   = out_chan_ff;
   assign rsp_chan.sample_out    = out_sample_ff;
   assign rsp_chan.frame_end_out = out_fe_ff;
   assign rsp_chan.saturated     = out_sat_ff;

endmodule

>>> tb/tb_multichannel_biquad_iir.sv
// Self-checking testbench for multichannel_biquad_iir: coefficient loads, directed
// sample table, then random interleaved channels under idle and stall patterns.
// Depends on biquad_pkg and the req/rsp/csr interfaces; results checked in order.
`timescale 1ns / 1ps

module tb_multichannel_biquad_iir;
   import biquad_pkg::*;

   localparam int CHANNELS       = DEF_CHANNELS;
   localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
   localparam int FRAC           = DEF_COEF_FRAC_BITS;
   localparam int SETTLE_CYCLES  = 6;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 240;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_HEAVY     = 77;
   localparam int IDLE_BOTH      = 32;
   localparam int MAX_GAP        = 40;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint ONE        = longint'(1) << FRAC;
   localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam longint A2_LIMIT   = (ONE * 4) / 5;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 frame_end;
   } sample_word_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      logic                 frame_end;
      logic                 saturated;
   } filtered_word_type;

   typedef enum logic {ROW_COEF, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {STYLE_STABLE, STYLE_RANDOM, STYLE_EXTREME} coef_style_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_IDX_BITS-1:0] reg_index;
      logic [CHAN_BITS-1:0]    channel;
      logic [COEF_BITS-1:0]    value;
      logic                    frame_end;
      logic                    known;
      logic [SAMPLE_W-1:0]     want_sample;
      logic                    want_sat;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 35;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // pass-through after reset: output equals input
      '{ROW_SAMPLE, '0, 3'd0, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF, 1'b0},
      '{ROW_SAMPLE, '0, 3'd7, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0000_0000, 1'b0, 1'b1, 24'h00_0000, 1'b0},
      '{ROW_SAMPLE, '0, 3'd5, 32'h00FF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF, 1'b0},
      '{ROW_SAMPLE, '0, 3'd2, 32'h0055_5555, 1'b0, 1'b1, 24'h55_5555, 1'b0},
      '{ROW_SAMPLE, '0, 3'd6, 32'h00AA_AAAA, 1'b1, 1'b1, 24'hAA_AAAA, 1'b0},
      // gain 0.5: halves land on ties, which round up
      '{ROW_COEF,   CSR_B0, '0, 32'h0800_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd1, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0001, 1'b0},
      '{ROW_SAMPLE, '0, 3'd1, 32'h00FF_FFFF, 1'b0, 1'b1, 24'h00_0000, 1'b0},
      '{ROW_SAMPLE, '0, 3'd1, 32'h0000_0003, 1'b1, 1'b1, 24'h00_0002, 1'b0},
      '{ROW_SAMPLE, '0, 3'd1, 32'h00FF_FFFD, 1'b0, 1'b1, 24'hFF_FFFF, 1'b0},
      // largest positive gain clips both ways
      '{ROW_COEF,   CSR_B0, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd4, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF, 1'b1},
      '{ROW_SAMPLE, '0, 3'd4, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000, 1'b1},
      '{ROW_SAMPLE, '0, 3'd4, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0008, 1'b0},
      // most negative gain flips the sign and clips
      '{ROW_COEF,   CSR_B0, '0, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd0, 32'h0080_0000, 1'b0, 1'b1, 24'h7F_FFFF, 1'b1},
      '{ROW_SAMPLE, '0, 3'd0, 32'h007F_FFFF, 1'b1, 1'b1, 24'h80_0000, 1'b1},
      // full biquad with runaway feedback
      '{ROW_COEF,   CSR_B0, '0, 32'h1000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_B1, '0, 32'h0800_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_B2, '0, 32'hF800_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_A1, '0, 32'hE000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_A2, '0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
      // unused indexes must not disturb any coefficient
      '{ROW_COEF,   CSR_SPARE_LO, '0, 32'hDEAD_BEEF, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_SPARE_HI, '0, 32'h8000_0001, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0010_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h007F_FFFF, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0080_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0001_2345, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0000_0000, 1'b1, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd7, 32'h0000_0100, 1'b1, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd7, 32'h00FF_F000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_COEF,   CSR_A2, '0, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, '0, 3'd3, 32'h0040_0000, 1'b1, 1'b0, '0, 1'b0}
   };

   logic clock;
   logic reset;

   biquad_csr_if                         csr_chan ();
   biquad_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan ();
   biquad_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_chan ();

   multichannel_biquad_iir #(
      .CHANNELS(CHANNELS),
      .SAMPLE_BITS(SAMPLE_W),
      .COEF_FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_chan(csr_chan),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // filter model state
   logic signed [COEF_BITS-1:0] coef_q [5];
   logic signed [SAMPLE_W-1:0]  hist_x1 [CHANNELS];
   logic signed [SAMPLE_W-1:0]  hist_x2 [CHANNELS];
   logic signed [SAMPLE_W-1:0]  hist_y1 [CHANNELS];
   logic signed [SAMPLE_W-1:0]  hist_y2 [CHANNELS];

   filtered_word_type pending_filtered [$];

   int   mismatches      = 0;
   int   results_checked = 0;
   int   clipped_results = 0;
   int   coef_writes     = 0;
   int   req_idle_pct    = 0;
   int   rsp_stall_pct   = 0;
   int   phase_no        = -1;
   logic hold_off        = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint rand_signed(input longint lim);
      return longint'($urandom_range(0, 32'(2 * lim))) - lim;
   endfunction

   // direct form I step for one word; advances the channel history
   function automatic filtered_word_type biquad_predict(input sample_word_type w);
      logic signed [SAMPLE_W-1:0] x_now;
      longint                     acc;
      longint                     y;
      filtered_word_type          r;
      x_now       = w.sample;
      r.channel   = w.channel;
      r.frame_end = w.frame_end;
      r.sample    = '0;
      r.saturated = 1'b0;
      if (int'(w.channel) < CHANNELS) begin
         acc = coef_q[CSR_B0] * x_now
             + coef_q[CSR_B1] * hist_x1[w.channel]
             + coef_q[CSR_B2] * hist_x2[w.channel]
             - coef_q[CSR_A1] * hist_y1[w.channel]
             - coef_q[CSR_A2] * hist_y2[w.channel];
         y = (acc + ROUND_HALF) >>> FRAC;
         if (y > SAMPLE_MAX) begin
            y           = SAMPLE_MAX;
            r.saturated = 1'b1;
         end else if (y < SAMPLE_MIN) begin
            y           = SAMPLE_MIN;
            r.saturated = 1'b1;
         end
         r.sample           = y[SAMPLE_W-1:0];
         hist_x2[w.channel] = hist_x1[w.channel];
         hist_x1[w.channel] = x_now;
         hist_y2[w.channel] = hist_y1[w.channel];
         hist_y1[w.channel] = r.sample;
      end
      return r;
   endfunction

   // valid stays high after acceptance; the caller lowers it when a gap follows
   task automatic offer_sample(input sample_word_type w, input logic known,
                               input filtered_word_type want);
      filtered_word_type model_out;
      req_chan.valid     <= 1'b1;
      req_chan.channel   <= w.channel;
      req_chan.sample_in <= w.sample;
      req_chan.frame_end <= w.frame_end;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      model_out = biquad_predict(w);
      pending_filtered.push_back(known ? want : model_out);
   endtask

   task automatic write_coef(input logic [CSR_IDX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      if (idx <= CSR_A2)
         coef_q[idx] = value;
      coef_writes++;
   endtask

   task automatic settle_idle();
      req_chan.valid <= 1'b0;
      while (pending_filtered.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, overridden by the long hold
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off)
            rsp_chan.ready <= 1'b0;
         else
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // long receiver hold while the sender keeps offering words
   initial begin
      wait (phase_no == PRESSURE_PHASE);
      repeat (16) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      filtered_word_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_checked++;
         if (rsp_chan.saturated === 1'b1)
            clipped_results++;
         if (pending_filtered.size() == 0) begin
            $error("unexpected result word: channel_out %0d sample_out %0d",
                   rsp_chan.channel_out, rsp_chan.sample_out);
            mismatches++;
         end else begin
            want = pending_filtered.pop_front();
            if (rsp_chan.channel_out !== want.channel) begin
               $error("channel_out: expected %0d, got %0d", want.channel,
                      rsp_chan.channel_out);
               mismatches++;
            end
            if (rsp_chan.sample_out !== want.sample) begin
               $error("sample_out: expected %0d, got %0d", $signed(want.sample),
                      rsp_chan.sample_out);
               mismatches++;
            end
            if (rsp_chan.frame_end_out !== want.frame_end) begin
               $error("frame_end_out: expected %0b, got %0b", want.frame_end,
                      rsp_chan.frame_end_out);
               mismatches++;
            end
            if (rsp_chan.saturated !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated,
                      rsp_chan.saturated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      sample_word_type             w;
      filtered_word_type           want;
      stim_row_type                row;
      logic                        last_row_sample;
      logic [CHAN_BITS-1:0]        last_ch;
      logic [CHAN_BITS-1:0]        rr_ch;
      logic                        rr_pick;
      int                          gap;
      int                          pick;
      longint                      a2;
      logic signed [COEF_BITS-1:0] new_coef [5];
      coef_style_type              style;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.channel   = '0;
      req_chan.sample_in = '0;
      req_chan.frame_end = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      foreach (coef_q[k])
         coef_q[k] = '0;
      coef_q[CSR_B0] = COEF_BITS'(ONE);
      foreach (hist_x1[k]) begin
         hist_x1[k] = '0;
         hist_x2[k] = '0;
         hist_y1[k] = '0;
         hist_y2[k] = '0;
      end
      last_row_sample = 1'b1;
      last_ch         = '0;
      rr_ch           = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_COEF) begin
            if (last_row_sample)
               settle_idle();
            write_coef(row.reg_index, row.value);
            last_row_sample = 1'b0;
         end else begin
            csr_chan.valid <= 1'b0;
            w    = '{row.channel, row.value[SAMPLE_W-1:0], row.frame_end};
            want = '{row.channel, row.want_sample, row.frame_end, row.want_sat};
            offer_sample(w, row.known, want);
            last_row_sample = 1'b1;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle_idle();
         style = (p % 4 == 1) ? STYLE_RANDOM : (p % 4 == 3) ? STYLE_EXTREME : STYLE_STABLE;
         case (style)
            STYLE_RANDOM: begin
               foreach (new_coef[k])
                  new_coef[k] = $urandom;
            end
            STYLE_EXTREME: begin
               foreach (new_coef[k]) begin
                  case ($urandom_range(0, 3))
                     0:       new_coef[k] = 32'h7FFF_FFFF;
                     1:       new_coef[k] = 32'h8000_0000;
                     2:       new_coef[k] = '0;
                     default: new_coef[k] = COEF_BITS'(ONE);
                  endcase
               end
            end
            default: begin
               // poles kept inside the stability triangle
               a2 = rand_signed(A2_LIMIT);
               new_coef[CSR_A2] = COEF_BITS'(a2);
               new_coef[CSR_A1] = COEF_BITS'(rand_signed(((ONE + a2) * 15) / 16));
               new_coef[CSR_B0] = COEF_BITS'(rand_signed(ONE / 2));
               new_coef[CSR_B1] = COEF_BITS'(rand_signed(ONE / 2));
               new_coef[CSR_B2] = COEF_BITS'(rand_signed(ONE / 2));
            end
         endcase
         for (int k = 0; k <= CSR_A2; k++)
            write_coef(CSR_IDX_BITS'(k), new_coef[k]);
         csr_chan.valid <= 1'b0;

         case (p % 4)
            0: begin
               req_idle_pct   = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               req_idle_pct   = IDLE_HEAVY;
               rsp_stall_pct <= 0;
            end
            2: begin
               req_idle_pct   = 0;
               rsp_stall_pct <= IDLE_HEAVY;
            end
            default: begin
               req_idle_pct   = IDLE_BOTH;
               rsp_stall_pct <= IDLE_BOTH;
            end
         endcase
         phase_no = p;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // interleaved frames, repeats on one channel, and random hops
            pick    = $urandom_range(0, 99);
            rr_pick = 1'b0;
            if (pick < 40) begin
               rr_ch     = rr_ch + 1'b1;
               w.channel = rr_ch;
               rr_pick   = 1'b1;
            end else if (pick < 65) begin
               w.channel = last_ch;
            end else begin
               w.channel = CHAN_BITS'($urandom);
            end
            case ($urandom_range(0, 9))
               0:       w.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
               1:       w.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
               2, 3:    w.sample = SAMPLE_W'($urandom_range(0, 64) - 32);
               default: w.sample = SAMPLE_W'($urandom);
            endcase
            w.frame_end = (rr_pick && rr_ch == CHAN_BITS'(CHANNELS - 1))
                        || ($urandom_range(0, 7) == 0);
            last_ch = w.channel;
            offer_sample(w, 1'b0, '0);

            gap = 0;
            while (gap < MAX_GAP && $urandom_range(0, 99) < req_idle_pct)
               gap++;
            if (gap != 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      settle_idle();
      $display("Filtered %0d words over %0d channels, %0d coefficient writes, %0d clipped.",
               results_checked, CHANNELS, coef_writes, clipped_results);
      $display("Flow: no idling, sender idle, receiver stalls, both, and a %0d-cycle hold.",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> multichannel_biquad_iir.f
src/biquad_pkg.sv
src/biquad_req_if.sv
src/biquad_rsp_if.sv
src/biquad_csr_if.sv
src/multichannel_biquad_iir.sv
tb/tb_multichannel_biquad_iir.sv
